FILE: design/svn_pkg.sv
package svn_pkg;

  // Sizes of the stores and of the datapath
  localparam int unsigned VTX_N   = 1024;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned EDGE_W  = 25;
  localparam int unsigned CROSS_W = 51;
  localparam int unsigned ACC_W   = 56;
  localparam int unsigned HALF_W  = 28;
  localparam int unsigned MUL_W   = 29;
  localparam int unsigned PROD_W  = 58;
  localparam int unsigned SUM_W   = 112;
  localparam int unsigned ROOT_W  = 56;
  localparam int unsigned REM_W   = 60;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned THR2_W  = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned SEQ_W   = 4;

  localparam logic [THR_W-1:0] THR_RESET = 16'd7;
  localparam logic [NORM_W-1:0] UNIT_ONE = 16'sd16384;

  // Last step index of the root and of the divide in the root/divide unit
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd55;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } svn_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRI_RA,
    ST_TRI_RB,
    ST_TRI_RC,
    ST_TRI_E2,
    ST_TRI_MUL,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_ACC,
    ST_RD_LATCH,
    ST_RD_SQ,
    ST_RD_CHK,
    ST_RD_SQRT,
    ST_RD_DIV,
    ST_RD_OUT
  } svn_state_e;

  typedef enum logic [1:0] {
    UM_IDLE,
    UM_SQRT,
    UM_DIV
  } svn_umode_e;

  typedef struct packed {
    logic sqrt_start;
    logic div_start;
  } svn_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } svn_stat_t;

  // Saturating accumulator update
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [CROSS_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W+1-CROSS_W){d[CROSS_W-1]}}, d};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

FILE: design/smooth_vertex_normal_engine.sv
// Load: taken in the accept cycle. Triangle: busy after the transfer for its
// 3 position reads, 6 products through one multiplier and 3 read-modify-writes.
// Read: paced by the bit-serial root (56 steps) and three 16-step divides in the shared
// root/divide unit, both skipped when degenerate; the result then waits in the output register.
// One item at a time. Reset (rst_ni low, asynchronous) returns to idle, empties the
// output register and sets the threshold to 7; vertex stores hold no reset value.
module smooth_vertex_normal_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svn_pkg::THR_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [svn_pkg::CMD_W-1:0]     command_i,
  input  logic [svn_pkg::IDX_W-1:0]     vertex_index_i,
  input  logic signed [svn_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [svn_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [svn_pkg::POS_W-1:0] pos_z_i,
  input  logic [svn_pkg::IDX_W-1:0]     corner_a_i,
  input  logic [svn_pkg::IDX_W-1:0]     corner_b_i,
  input  logic [svn_pkg::IDX_W-1:0]     corner_c_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [svn_pkg::IDX_W-1:0]     out_index_o,
  output logic signed [svn_pkg::NORM_W-1:0] norm_x_o,
  output logic signed [svn_pkg::NORM_W-1:0] norm_y_o,
  output logic signed [svn_pkg::NORM_W-1:0] norm_z_o,
  output logic                          degenerate_o
);
  import svn_pkg::*;

  svn_state_e                state_q, state_d;
  logic [SEQ_W-1:0]          cnt_q, cnt_d;
  logic [SEQ_W-1:0]          j;
  logic [THR_W-1:0]          thr_q;

  logic [IDX_W-1:0]          idx_q;
  logic [IDX_W-1:0]          corner_q [3];

  // Stores
  logic [3*POS_W-1:0]        pos_mem [VTX_N];
  logic [3*ACC_W-1:0]        acc_mem [VTX_N];
  logic [3*POS_W-1:0]        pos_rd_q;
  logic [3*ACC_W-1:0]        acc_rd_q;
  logic                      pos_we, acc_we;
  logic [IDX_W-1:0]          pos_raddr, acc_addr;
  logic [3*ACC_W-1:0]        acc_wdata;

  // Datapath registers
  logic signed [POS_W-1:0]   pa_q [3];
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [CROSS_W-1:0] cross_q [3];
  logic signed [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]          mag_q [3];
  logic                      neg_q [3];
  logic [SUM_W-1:0]          sum_q;
  logic [THR2_W-1:0]         thr2_q;
  logic [NORM_W-1:0]         norm_q [3];
  logic                      deg_q;
  logic                      deg_now;

  // Shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // Root/divide unit
  svn_ctrl_t                 ctrl;
  svn_stat_t                 stat;
  logic [ROOT_W-1:0]         root;
  logic [QUO_W-1:0]          quot;
  logic [ACC_W-1:0]          dividend;

  // Output register
  logic                      out_valid_q;
  logic                      out_load;
  logic [IDX_W-1:0]          out_index_q;
  logic [NORM_W-1:0]         out_norm_q [3];
  logic                      out_deg_q;

  logic [SUM_W-1:0]          sq_term;
  logic [SUM_W-1:0]          sq_ext;

  assign j       = cnt_q - 1'b1;
  assign deg_now = (sum_q <= {{(SUM_W-THR2_W-32){1'b0}}, thr2_q, 32'd0});

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ctrl      = '0;
    pos_we    = 1'b0;
    acc_we    = 1'b0;
    acc_wdata = '0;
    pos_raddr = corner_q[0];
    acc_addr  = idx_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        acc_addr = vertex_index_i;
        cnt_d    = '0;
        if (in_valid_i) begin
          case (command_i)
            CMD_LOAD: begin
              pos_we = 1'b1;
              acc_we = 1'b1;
            end
            CMD_TRI:  state_d = ST_TRI_RA;
            CMD_READ: state_d = ST_RD_ACC;
            default:  ;
          endcase
        end
      end
      ST_TRI_RA: begin
        pos_raddr = corner_q[0];
        state_d   = ST_TRI_RB;
      end
      ST_TRI_RB: begin
        pos_raddr = corner_q[1];
        state_d   = ST_TRI_RC;
      end
      ST_TRI_RC: begin
        pos_raddr = corner_q[2];
        state_d   = ST_TRI_E2;
      end
      ST_TRI_E2: state_d = ST_TRI_MUL;
      ST_TRI_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd6) begin
          cnt_d   = '0;
          state_d = ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        acc_addr = corner_q[cnt_q[1:0]];
        state_d  = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        acc_addr  = corner_q[cnt_q[1:0]];
        acc_we    = 1'b1;
        acc_wdata = {sat_add(acc_rd_q[3*ACC_W-1 -: ACC_W], cross_q[0]),
                     sat_add(acc_rd_q[2*ACC_W-1 -: ACC_W], cross_q[1]),
                     sat_add(acc_rd_q[ACC_W-1:0], cross_q[2])};
        if (cnt_q == 4'd2) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_ACC_RD;
        end
      end
      ST_RD_ACC:   state_d = ST_RD_LATCH;
      ST_RD_LATCH: begin
        cnt_d   = '0;
        state_d = ST_RD_SQ;
      end
      ST_RD_SQ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd10) begin
          cnt_d   = '0;
          state_d = ST_RD_CHK;
        end
      end
      ST_RD_CHK: begin
        if (deg_now) begin
          state_d = ST_RD_OUT;
        end else begin
          ctrl.sqrt_start = 1'b1;
          state_d         = ST_RD_SQRT;
        end
      end
      ST_RD_SQRT: begin
        if (stat.done) begin
          ctrl.div_start = 1'b1;
          cnt_d          = '0;
          state_d        = ST_RD_DIV;
        end
      end
      ST_RD_DIV: begin
        if (stat.done) begin
          if (cnt_q == 4'd2) begin
            state_d = ST_RD_OUT;
          end else begin
            cnt_d          = cnt_q + 1'b1;
            ctrl.div_start = 1'b1;
          end
        end
      end
      ST_RD_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Dividend follows the component about to start
  always_comb begin
    case (cnt_d[1:0])
      2'd0:    dividend = mag_q[0];
      2'd1:    dividend = mag_q[1];
      default: dividend = mag_q[2];
    endcase
  end

  // Multiplier operands: cross product terms, partial squares of the magnitudes, or the squared threshold
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_TRI_MUL) begin
      case (cnt_q)
        4'd0: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
        4'd1: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
        4'd2: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
        4'd3: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
        4'd4: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
        4'd5: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
        default: ;
      endcase
    end else if (state_q == ST_RD_SQ) begin
      case (cnt_q)
        4'd0: begin mul_a = {1'b0, mag_q[0][HALF_W-1:0]}; mul_b = mul_a; end
        4'd1: begin mul_a = {1'b0, mag_q[0][ACC_W-1:HALF_W]};
                    mul_b = {1'b0, mag_q[0][HALF_W-1:0]}; end
        4'd2: begin mul_a = {1'b0, mag_q[0][ACC_W-1:HALF_W]}; mul_b = mul_a; end
        4'd3: begin mul_a = {1'b0, mag_q[1][HALF_W-1:0]}; mul_b = mul_a; end
        4'd4: begin mul_a = {1'b0, mag_q[1][ACC_W-1:HALF_W]};
                    mul_b = {1'b0, mag_q[1][HALF_W-1:0]}; end
        4'd5: begin mul_a = {1'b0, mag_q[1][ACC_W-1:HALF_W]}; mul_b = mul_a; end
        4'd6: begin mul_a = {1'b0, mag_q[2][HALF_W-1:0]}; mul_b = mul_a; end
        4'd7: begin mul_a = {1'b0, mag_q[2][ACC_W-1:HALF_W]};
                    mul_b = {1'b0, mag_q[2][HALF_W-1:0]}; end
        4'd8: begin mul_a = {1'b0, mag_q[2][ACC_W-1:HALF_W]}; mul_b = mul_a; end
        4'd9: begin mul_a = {{(MUL_W-THR_W){1'b0}}, thr_q}; mul_b = mul_a; end
        default: ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // Place a partial square: low*low, 2*high*low, high*high
  always_comb begin
    sq_ext = {{(SUM_W-2*HALF_W){1'b0}}, prod_q[2*HALF_W-1:0]};
    case (j)
      4'd1, 4'd4, 4'd7: sq_term = sq_ext << (HALF_W + 1);
      4'd2, 4'd5, 4'd8: sq_term = sq_ext << (2 * HALF_W);
      default:          sq_term = sq_ext;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stores, read data registered
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[vertex_index_i] <= {pos_x_i, pos_y_i, pos_z_i};
    end
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    acc_rd_q <= acc_mem[acc_addr];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      idx_q       <= vertex_index_i;
      corner_q[0] <= corner_a_i;
      corner_q[1] <= corner_b_i;
      corner_q[2] <= corner_c_i;
    end
    if (state_q == ST_TRI_RB) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= pos_rd_q[(3-k)*POS_W-1 -: POS_W];
      end
    end
    if (state_q == ST_TRI_RC) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= EDGE_W'($signed(pos_rd_q[(3-k)*POS_W-1 -: POS_W])) - EDGE_W'(pa_q[k]);
      end
    end
    if (state_q == ST_TRI_E2) begin
      for (int k = 0; k < 3; k++) begin
        e2_q[k] <= EDGE_W'($signed(pos_rd_q[(3-k)*POS_W-1 -: POS_W])) - EDGE_W'(pa_q[k]);
      end
    end
    prod_q <= mul_p;
    // cross product: first term sets, second subtracts
    if (state_q == ST_TRI_MUL && cnt_q != '0) begin
      if (j[0]) begin
        cross_q[j[2:1]] <= cross_q[j[2:1]] - prod_q[CROSS_W-1:0];
      end else begin
        cross_q[j[2:1]] <= prod_q[CROSS_W-1:0];
      end
    end
    if (state_q == ST_RD_LATCH) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= acc_rd_q[(3-k)*ACC_W-1];
        mag_q[k] <= acc_rd_q[(3-k)*ACC_W-1] ? (~acc_rd_q[(3-k)*ACC_W-1 -: ACC_W] + 1'b1)
                                             : acc_rd_q[(3-k)*ACC_W-1 -: ACC_W];
      end
      sum_q <= '0;
    end
    if (state_q == ST_RD_SQ && cnt_q != '0) begin
      if (j == 4'd9) begin
        thr2_q <= prod_q[THR2_W-1:0];
      end else begin
        sum_q <= sum_q + sq_term;
      end
    end
    if (state_q == ST_RD_CHK) begin
      deg_q <= deg_now;
      for (int k = 0; k < 3; k++) begin
        norm_q[k] <= '0;
      end
    end
    if (state_q == ST_RD_DIV && stat.done) begin
      norm_q[cnt_q[1:0]] <= neg_q[cnt_q[1:0]] ? (~quot + 1'b1) : quot;
    end
    if (out_load) begin
      out_index_q <= idx_q;
      out_deg_q   <= deg_q;
      for (int k = 0; k < 3; k++) begin
        out_norm_q[k] <= norm_q[k];
      end
    end
  end

  svn_rootdiv u_rootdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .radicand_i (sum_q),
    .dividend_i (dividend),
    .stat_o     (stat),
    .root_o     (root),
    .quot_o     (quot)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign norm_x_o     = out_norm_q[0];
  assign norm_y_o     = out_norm_q[1];
  assign norm_z_o     = out_norm_q[2];
  assign degenerate_o = out_deg_q;

  // Divisor must be nonzero whenever a divide starts
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.div_start |-> root != '0)
    else $error("divide started with zero root");

  // Unit only runs while the sequencer waits on it
  a_unit_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> (state_q == ST_RD_SQRT || state_q == ST_RD_DIV))
    else $error("root/divide unit busy outside read");

  // Degenerate results carry a zero normal
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0)
    else $error("degenerate result with nonzero normal");

  // The x component stays within unit length
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(norm_x_o) <= $signed(UNIT_ONE)
                     && $signed(norm_x_o) >= -$signed(UNIT_ONE)))
    else $error("normal component out of range");

  // A new result comes only from the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RD_OUT)
    else $error("result raised outside output state");

endmodule

FILE: design/svn_rootdiv.sv
module svn_rootdiv (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  svn_pkg::svn_ctrl_t       ctrl_i,
  input  logic [svn_pkg::SUM_W-1:0] radicand_i,
  input  logic [svn_pkg::ACC_W-1:0] dividend_i,
  output svn_pkg::svn_stat_t       stat_o,
  output logic [svn_pkg::ROOT_W-1:0] root_o,
  output logic [svn_pkg::QUO_W-1:0]  quot_o
);
  import svn_pkg::*;

  svn_umode_e          mode_q, mode_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [SUM_W-1:0]    rad_q, rad_d;
  logic [QUO_W-1:0]    quot_q, quot_d;

  logic [REM_W-1:0]    trial_a, trial_b, keep;
  logic [REM_W:0]      diff;
  logic                ge;

  // Shared compare/subtract: root trial or divisor
  always_comb begin
    if (mode_q == UM_SQRT) begin
      trial_a = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
      trial_b = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
    end else begin
      trial_a = rem_q;
      trial_b = {{(REM_W-ROOT_W){1'b0}}, root_q};
    end
    diff = {1'b0, trial_a} - {1'b0, trial_b};
    ge   = ~diff[REM_W];
    keep = ge ? diff[REM_W-1:0] : trial_a;
  end

  // Step sequencer
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    root_d = root_q;
    rad_d  = rad_q;
    quot_d = quot_q;
    case (mode_q)
      UM_SQRT: begin
        rem_d  = keep;
        root_d = {root_q[ROOT_W-2:0], ge};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          mode_d = UM_IDLE;
          done_d = 1'b1;
        end
      end
      UM_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          // rounding step: twice the remainder against the divisor
          quot_d = quot_q + {{(QUO_W-1){1'b0}}, ge};
          mode_d = UM_IDLE;
          done_d = 1'b1;
        end else begin
          rem_d  = keep << 1;
          quot_d = {quot_q[QUO_W-2:0], ge};
        end
      end
      default: begin
        if (ctrl_i.sqrt_start) begin
          mode_d = UM_SQRT;
          cnt_d  = '0;
          rem_d  = '0;
          root_d = '0;
          rad_d  = radicand_i;
        end else if (ctrl_i.div_start) begin
          mode_d = UM_DIV;
          cnt_d  = '0;
          rem_d  = {{(REM_W-ACC_W){1'b0}}, dividend_i};
          quot_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= UM_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = (mode_q != UM_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = root_q;
  assign quot_o      = quot_q;

endmodule
